FILE: rtl/core/cpl_pkg.sv
// Shared constants, operand codes and the multiply-accumulate schedule for the line-pair solver.
package cpl_pkg;

    localparam int CoordWidthDef   = 32;
    localparam int FractionBitsDef = 16;
    localparam int MagWidthDef     = 5 * CoordWidthDef + 8;
    localparam int TolWidth        = 31;
    localparam int CfgDataWidth    = 32;
    localparam logic [63:0] ParallelRecip = 64'd100000000000000;
    localparam int NumUops         = 22;

    // operand sources for the shared multiplier
    typedef enum logic [3:0] {
        SRC_D1, SRC_D2, SRC_W, SRC_A, SRC_B, SRC_C, SRC_DD, SRC_E, SRC_TOL
    } t_src;

    // accumulator destinations
    typedef enum logic [3:0] {
        DST_A, DST_B, DST_C, DST_DD, DST_E, DST_DEN, DST_N1, DST_N2, DST_TT
    } t_dst;

    typedef struct packed {
        t_src       src_a;
        t_src       src_b;
        logic [1:0] axis;
        t_dst       dst;
        logic       sub;
    } t_uop;

    // dot products, then den = ac - bb, n1 = be - c*dd, n2 = ae - b*dd, tol^2
    function automatic t_uop uop_at(logic [4:0] step);
        t_uop u;
        u = '{src_a: SRC_D1, src_b: SRC_D1, axis: 2'd0, dst: DST_A, sub: 1'b0};
        case (step) inside
            [5'd0:5'd2]: begin
                u.src_a = SRC_D1; u.src_b = SRC_D1; u.axis = 2'(step); u.dst = DST_A;
            end
            [5'd3:5'd5]: begin
                u.src_a = SRC_D1; u.src_b = SRC_D2; u.axis = 2'(step - 5'd3); u.dst = DST_B;
            end
            [5'd6:5'd8]: begin
                u.src_a = SRC_D2; u.src_b = SRC_D2; u.axis = 2'(step - 5'd6); u.dst = DST_C;
            end
            [5'd9:5'd11]: begin
                u.src_a = SRC_W; u.src_b = SRC_D1; u.axis = 2'(step - 5'd9); u.dst = DST_DD;
            end
            [5'd12:5'd14]: begin
                u.src_a = SRC_W; u.src_b = SRC_D2; u.axis = 2'(step - 5'd12); u.dst = DST_E;
            end
            5'd15: begin u.src_a = SRC_A; u.src_b = SRC_C;  u.dst = DST_DEN; end
            5'd16: begin u.src_a = SRC_B; u.src_b = SRC_B;  u.dst = DST_DEN; u.sub = 1'b1; end
            5'd17: begin u.src_a = SRC_B; u.src_b = SRC_E;  u.dst = DST_N1; end
            5'd18: begin u.src_a = SRC_C; u.src_b = SRC_DD; u.dst = DST_N1; u.sub = 1'b1; end
            5'd19: begin u.src_a = SRC_A; u.src_b = SRC_E;  u.dst = DST_N2; end
            5'd20: begin u.src_a = SRC_B; u.src_b = SRC_DD; u.dst = DST_N2; u.sub = 1'b1; end
            5'd21: begin u.src_a = SRC_TOL; u.src_b = SRC_TOL; u.dst = DST_TT; end
            default: ;
        endcase
        return u;
    endfunction

endpackage

FILE: rtl/core/cpl_mul.sv
// Bit-serial shift-add multiplier on magnitudes, one multiplier bit per cycle.
module cpl_mul
    import cpl_pkg::*;
#(
    parameter int MagWidth = MagWidthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MagWidth-1:0] i_mcand,
    input  logic [MagWidth-1:0] i_mplier,
    output logic                o_done,
    output logic [MagWidth-1:0] o_prod
);

    logic [MagWidth-1:0] r_acc;
    logic [MagWidth-1:0] r_mcand;
    logic [MagWidth-1:0] r_mplier;
    logic                r_busy;
    logic                r_done;

    // control: run until the multiplier runs out of ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_mplier == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
        end else if (r_busy && (r_mplier != '0)) begin
            if (r_mplier[0]) r_acc <= r_acc + r_mcand;
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

FILE: rtl/core/cpl_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle, rounded half away from zero.
module cpl_div
    import cpl_pkg::*;
#(
    parameter int MagWidth = MagWidthDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [MagWidth-1:0] i_num,
    input  logic [MagWidth-1:0] i_den,
    output logic                o_done,
    output logic [MagWidth-1:0] o_quo
);

    localparam int CntWidth = $clog2(MagWidth);

    logic [MagWidth-1:0] r_rem;
    logic [MagWidth-1:0] r_quo;
    logic [MagWidth-1:0] r_den;
    logic [CntWidth-1:0] r_cnt;
    logic                r_busy;
    logic                r_rnd;
    logic                r_done;
    logic [MagWidth:0]   trial;
    logic [MagWidth:0]   diff;
    logic                fits;
    logic                round_up;

    // one restoring step: bring in the next dividend bit
    assign trial    = {r_rem, r_quo[MagWidth-1]};
    assign diff     = trial - {1'b0, r_den};
    assign fits     = (trial >= {1'b0, r_den});
    assign round_up = ({r_rem, 1'b0} >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_rnd  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CntWidth'(MagWidth - 1))) begin
                r_busy <= 1'b0;
                r_rnd  <= 1'b1;
            end else if (r_rnd) begin
                r_rnd  <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: dividend shifts out of r_quo as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[MagWidth-1:0] : trial[MagWidth-1:0];
            r_quo <= {r_quo[MagWidth-2:0], fits};
            r_cnt <= r_cnt + 1'b1;
        end else if (r_rnd && round_up) begin
            r_quo <= r_quo + 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/core/closest_points_two_lines.sv
// Top level: closest points, midpoint and gap between two 3D lines in signed fixed point.
// An item with line_select low stores the first line and gives no result; an item with
// line_select high pairs with the stored line and gives one result. A second-line item runs
// a sequencer around one bit-serial multiplier and one bit-serial divider: 31 multiplies at
// one multiplier bit per cycle, six divides and a square root; an invalid pair skips them.
// Input is taken only while no pair is in work; a finished result waits in the output
// register while the next line is taken. Lines closer to parallel than 1e-14 in the
// denominator, or an invalid line, give a result with every field zero.
module closest_points_two_lines
    import cpl_pkg::*;
#(
    parameter int COORD_WIDTH   = CoordWidthDef,
    parameter int FRACTION_BITS = FractionBitsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // line input
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_line_select,
    input  logic signed [COORD_WIDTH-1:0] i_line_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_line_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_line_point_z,
    input  logic signed [COORD_WIDTH-1:0] i_line_dir_x,
    input  logic signed [COORD_WIDTH-1:0] i_line_dir_y,
    input  logic signed [COORD_WIDTH-1:0] i_line_dir_z,
    input  logic                          i_line_ok,
    // result output
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [COORD_WIDTH-1:0] o_near_first_x,
    output logic signed [COORD_WIDTH-1:0] o_near_first_y,
    output logic signed [COORD_WIDTH-1:0] o_near_first_z,
    output logic signed [COORD_WIDTH-1:0] o_near_second_x,
    output logic signed [COORD_WIDTH-1:0] o_near_second_y,
    output logic signed [COORD_WIDTH-1:0] o_near_second_z,
    output logic        [COORD_WIDTH-1:0] o_gap_length,
    output logic signed [COORD_WIDTH-1:0] o_mid_x,
    output logic signed [COORD_WIDTH-1:0] o_mid_y,
    output logic signed [COORD_WIDTH-1:0] o_mid_z,
    output logic                          o_result_ok,
    output logic                          o_lines_meet,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [CfgDataWidth-1:0]       pwdata,
    output logic [CfgDataWidth-1:0]       prdata,
    output logic                          pready
);

    localparam int W  = COORD_WIDTH;
    localparam int M  = 5 * W + 8;
    localparam int R  = 2 * W + 4;
    localparam int TW = 4 * FRACTION_BITS + 50;
    localparam int RcWidth = $clog2(W + 2);
    localparam logic [TW-1:0] ParTh =
        (({{(TW-1){1'b0}}, 1'b1} << (4 * FRACTION_BITS)) + TW'(ParallelRecip) - TW'(1))
        / TW'(ParallelRecip);
    localparam logic signed [W+2:0] SumMax = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SumMin = {4'b1111, {(W-1){1'b0}}};
    localparam logic [W+1:0] QSat = {1'b1, {(W+1){1'b0}}};

    typedef struct packed {
        logic         neg;
        logic [M-1:0] mag;
    } t_sm;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_PREP  = 10'b0000000010,
        S_MAC   = 10'b0000000100,
        S_CHECK = 10'b0000001000,
        S_PMUL  = 10'b0000010000,
        S_PDIV  = 10'b0000100000,
        S_PSUM  = 10'b0001000000,
        S_SQMUL = 10'b0010000000,
        S_ROOT  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } t_state;

    // sign-magnitude helpers
    function automatic t_sm sm_from_int(logic [W:0] v);
        t_sm        r;
        logic [W:0] a;
        a     = v[W] ? (~v + 1'b1) : v;
        r.neg = v[W];
        r.mag = M'(a);
        return r;
    endfunction

    function automatic t_sm sm_from_coord(logic [W-1:0] v);
        return sm_from_int({v[W-1], v});
    endfunction

    function automatic t_sm sm_add(t_sm x, t_sm y);
        t_sm r;
        if (x.neg == y.neg) begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end else if (x.mag >= y.mag) begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end else begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == '0) r.neg = 1'b0;
        return r;
    endfunction

    // point plus rounded offset, saturated to the coordinate range
    function automatic logic [W-1:0] point_sum(logic [W-1:0] p, logic [M-1:0] q, logic neg);
        logic [W+1:0]        qm;
        logic signed [W+2:0] qs;
        logic signed [W+2:0] s;
        logic [W-1:0]        r;
        qm = (|q[M-1:W+1]) ? QSat : q[W+1:0];
        qs = neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
        s  = $signed({{3{p[W-1]}}, p}) + qs;
        if (s > SumMax)      r = SumMax[W-1:0];
        else if (s < SumMin) r = SumMin[W-1:0];
        else                 r = s[W-1:0];
        return r;
    endfunction

    t_state        r_state;
    logic          r_wait;
    logic          r_line1_ok;
    logic          r_res_ok;
    logic          r_out_valid;
    logic          r_mul_neg;
    logic          r_line;
    logic [1:0]    r_axis;
    logic [4:0]    r_step;
    logic [TolWidth-1:0] r_tol;

    logic [W-1:0]  r_p1 [3];
    logic [W-1:0]  r_d1 [3];
    logic [W-1:0]  r_p2 [3];
    logic [W-1:0]  r_d2 [3];
    logic [W-1:0]  r_q1 [3];
    logic [W-1:0]  r_q2 [3];
    t_sm           r_w  [3];
    t_sm           r_a, r_b, r_c, r_dd, r_e, r_den, r_n1, r_n2, r_tt, r_sq, r_prod;
    logic [M-1:0]  r_quo;

    logic [R-1:0]  r_rad;
    logic [W+1:0]  r_rrem;
    logic [W+1:0]  r_root;
    logic [RcWidth-1:0] r_rcnt;

    logic [W-1:0]  r_o_n1 [3];
    logic [W-1:0]  r_o_n2 [3];
    logic [W-1:0]  r_o_mid [3];
    logic [W-1:0]  r_o_gap;
    logic          r_o_ok;
    logic          r_o_meet;

    t_uop          uop;
    t_sm           mul_a, mul_b, prod, n_acc, n_sq, diff;
    logic          mul_start, mul_done, div_start, div_done;
    logic [M-1:0]  mul_prod, div_quo;
    logic          in_acc, cfg_wr, den_small;
    logic [W+3:0]  rem_t, root_trial;
    logic          root_fits;
    logic [W:0]    mid_sum [3];

    assign in_acc     = i_in_valid && o_in_ready;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign o_in_ready = (r_state == S_IDLE);
    assign uop        = uop_at(r_step);
    assign den_small  = ({{TW{1'b0}}, r_den.mag} < {{M{1'b0}}, ParTh});

    // multiplier operand source select
    function automatic t_sm sel_src(t_src s, logic [1:0] ax);
        t_sm v;
        case (s)
            SRC_D1:  v = sm_from_coord(r_d1[ax]);
            SRC_D2:  v = sm_from_coord(r_d2[ax]);
            SRC_W:   v = r_w[ax];
            SRC_A:   v = r_a;
            SRC_B:   v = r_b;
            SRC_C:   v = r_c;
            SRC_DD:  v = r_dd;
            SRC_E:   v = r_e;
            SRC_TOL: v = '{neg: 1'b0, mag: M'(r_tol)};
            default: v = '0;
        endcase
        return v;
    endfunction

    // difference of the two near points on the current axis
    assign diff = sm_from_int($signed({r_q1[r_axis][W-1], r_q1[r_axis]})
                              - $signed({r_q2[r_axis][W-1], r_q2[r_axis]}));

    always_comb begin
        case (r_state)
            S_MAC: begin
                mul_a = sel_src(uop.src_a, uop.axis);
                mul_b = sel_src(uop.src_b, uop.axis);
            end
            S_PMUL: begin
                mul_a = r_line ? r_n2 : r_n1;
                mul_b = sm_from_coord(r_line ? r_d2[r_axis] : r_d1[r_axis]);
            end
            S_SQMUL: begin
                mul_a = diff;
                mul_b = diff;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_start = !r_wait && ((r_state == S_MAC) || (r_state == S_PMUL)
                                   || (r_state == S_SQMUL));
    assign div_start = !r_wait && (r_state == S_PDIV);

    // signed product of the finished multiply, negated for subtracting terms
    always_comb begin
        prod.mag = mul_prod;
        prod.neg = (r_mul_neg ^ ((r_state == S_MAC) && uop.sub)) && (mul_prod != '0);
    end

    always_comb begin
        case (uop.dst)
            DST_A:   n_acc = sm_add(r_a, prod);
            DST_B:   n_acc = sm_add(r_b, prod);
            DST_C:   n_acc = sm_add(r_c, prod);
            DST_DD:  n_acc = sm_add(r_dd, prod);
            DST_E:   n_acc = sm_add(r_e, prod);
            DST_DEN: n_acc = sm_add(r_den, prod);
            DST_N1:  n_acc = sm_add(r_n1, prod);
            DST_N2:  n_acc = sm_add(r_n2, prod);
            DST_TT:  n_acc = sm_add(r_tt, prod);
            default: n_acc = '0;
        endcase
    end

    assign n_sq = sm_add(r_sq, prod);

    // square root: two radicand bits per step
    assign rem_t      = {r_rrem, r_rad[R-1:R-2]};
    assign root_trial = {r_root, 2'b01};
    assign root_fits  = (rem_t >= root_trial);

    cpl_mul #(.MagWidth(M)) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_mcand  (mul_a.mag),
        .i_mplier (mul_b.mag),
        .o_done   (mul_done),
        .o_prod   (mul_prod)
    );

    cpl_div #(.MagWidth(M)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_prod.mag),
        .i_den   (r_den.mag),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // midpoint, floor of the half sum
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mid_sum[k] = {r_q1[k][W-1], r_q1[k]} + {r_q2[k][W-1], r_q2[k]};
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wait      <= 1'b0;
            r_line1_ok  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tol       <= '0;
        end else begin
            if (cfg_wr && !paddr[2]) r_tol <= pwdata[TolWidth-1:0];
            // a new result in S_DONE takes over the output register instead
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) r_out_valid <= 1'b0;
            if (mul_start) begin
                r_wait    <= 1'b1;
                r_mul_neg <= mul_a.neg ^ mul_b.neg;
            end
            if (div_start) r_wait <= 1'b1;

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (!i_line_select) begin
                            r_p1[0] <= i_line_point_x;
                            r_p1[1] <= i_line_point_y;
                            r_p1[2] <= i_line_point_z;
                            r_d1[0] <= i_line_dir_x;
                            r_d1[1] <= i_line_dir_y;
                            r_d1[2] <= i_line_dir_z;
                            r_line1_ok <= i_line_ok;
                        end else begin
                            r_p2[0] <= i_line_point_x;
                            r_p2[1] <= i_line_point_y;
                            r_p2[2] <= i_line_point_z;
                            r_d2[0] <= i_line_dir_x;
                            r_d2[1] <= i_line_dir_y;
                            r_d2[2] <= i_line_dir_z;
                            if (r_line1_ok && i_line_ok) begin
                                r_state <= S_PREP;
                            end else begin
                                r_res_ok <= 1'b0;
                                r_state  <= S_DONE;
                            end
                        end
                    end
                end
                S_PREP: begin
                    for (int k = 0; k < 3; k++) begin
                        r_w[k] <= sm_from_int($signed({r_p1[k][W-1], r_p1[k]})
                                              - $signed({r_p2[k][W-1], r_p2[k]}));
                    end
                    r_a <= '0; r_b <= '0; r_c <= '0; r_dd <= '0; r_e <= '0;
                    r_den <= '0; r_n1 <= '0; r_n2 <= '0; r_tt <= '0;
                    r_step  <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (mul_done) begin
                        r_wait <= 1'b0;
                        case (uop.dst)
                            DST_A:   r_a   <= n_acc;
                            DST_B:   r_b   <= n_acc;
                            DST_C:   r_c   <= n_acc;
                            DST_DD:  r_dd  <= n_acc;
                            DST_E:   r_e   <= n_acc;
                            DST_DEN: r_den <= n_acc;
                            DST_N1:  r_n1  <= n_acc;
                            DST_N2:  r_n2  <= n_acc;
                            DST_TT:  r_tt  <= n_acc;
                            default: ;
                        endcase
                        if (r_step == 5'(NumUops - 1)) r_state <= S_CHECK;
                        else r_step <= r_step + 1'b1;
                    end
                end
                S_CHECK: begin
                    if (den_small) begin
                        r_res_ok <= 1'b0;
                        r_state  <= S_DONE;
                    end else begin
                        r_axis  <= '0;
                        r_line  <= 1'b0;
                        r_state <= S_PMUL;
                    end
                end
                S_PMUL: begin
                    if (mul_done) begin
                        r_wait  <= 1'b0;
                        r_prod  <= prod;
                        r_state <= S_PDIV;
                    end
                end
                S_PDIV: begin
                    if (div_done) begin
                        r_wait  <= 1'b0;
                        r_quo   <= div_quo;
                        r_state <= S_PSUM;
                    end
                end
                S_PSUM: begin
                    if (!r_line) begin
                        r_q1[r_axis] <= point_sum(r_p1[r_axis], r_quo, r_prod.neg);
                        r_line  <= 1'b1;
                        r_state <= S_PMUL;
                    end else begin
                        r_q2[r_axis] <= point_sum(r_p2[r_axis], r_quo, r_prod.neg);
                        r_line <= 1'b0;
                        if (r_axis == 2'd2) begin
                            r_axis  <= '0;
                            r_sq    <= '0;
                            r_state <= S_SQMUL;
                        end else begin
                            r_axis  <= r_axis + 1'b1;
                            r_state <= S_PMUL;
                        end
                    end
                end
                S_SQMUL: begin
                    if (mul_done) begin
                        r_wait <= 1'b0;
                        r_sq   <= n_sq;
                        if (r_axis == 2'd2) begin
                            r_rad   <= n_sq.mag[R-1:0];
                            r_rrem  <= '0;
                            r_root  <= '0;
                            r_rcnt  <= '0;
                            r_state <= S_ROOT;
                        end else begin
                            r_axis <= r_axis + 1'b1;
                        end
                    end
                end
                S_ROOT: begin
                    r_rad  <= r_rad << 2;
                    r_rrem <= root_fits ? (W+2)'(rem_t - root_trial) : rem_t[W+1:0];
                    r_root <= {r_root[W:0], root_fits};
                    r_rcnt <= r_rcnt + 1'b1;
                    if (r_rcnt == RcWidth'(W + 1)) begin
                        r_res_ok <= 1'b1;
                        r_state  <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register, zeroed for an invalid pair
    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) begin
            for (int k = 0; k < 3; k++) begin
                r_o_n1[k]  <= r_res_ok ? r_q1[k] : '0;
                r_o_n2[k]  <= r_res_ok ? r_q2[k] : '0;
                r_o_mid[k] <= r_res_ok ? mid_sum[k][W:1] : '0;
            end
            if (!r_res_ok)              r_o_gap <= '0;
            else if (|r_root[W+1:W])    r_o_gap <= '1;
            else                        r_o_gap <= r_root[W-1:0];
            r_o_ok   <= r_res_ok;
            r_o_meet <= r_res_ok && (r_sq.mag <= r_tt.mag);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_near_first_x  = r_o_n1[0];
    assign o_near_first_y  = r_o_n1[1];
    assign o_near_first_z  = r_o_n1[2];
    assign o_near_second_x = r_o_n2[0];
    assign o_near_second_y = r_o_n2[1];
    assign o_near_second_z = r_o_n2[2];
    assign o_gap_length    = r_o_gap;
    assign o_mid_x         = r_o_mid[0];
    assign o_mid_y         = r_o_mid[1];
    assign o_mid_z         = r_o_mid[2];
    assign o_result_ok     = r_o_ok;
    assign o_lines_meet    = r_o_meet;

    // register read
    assign prdata = paddr[2] ? '0 : CfgDataWidth'(r_tol);
    assign pready = 1'b1;

    // checks
    a_zero_when_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_result_ok |-> !o_lines_meet && (o_gap_length == '0)
            && (o_near_first_x == '0) && (o_near_second_z == '0) && (o_mid_y == '0))
        else $error("invalid result carries nonzero fields");

    a_meet_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_lines_meet |-> o_result_ok)
        else $error("lines_meet without result_ok");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_wait)
        else $error("arithmetic unit busy while idle");

    a_store_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !i_line_select && !r_out_valid |=> !r_out_valid)
        else $error("first line produced a result");

endmodule
